// ===== src/b2b_pkg.sv =====
// ----------------------------------------------------------------------------
// b2b_pkg
// Shared constants and types for the binary to BCD converter.
// ----------------------------------------------------------------------------
package b2b_pkg;

  localparam int VALUE_W           = 32;
  localparam int BCD_W             = 40;
  localparam int COUNT_W           = 4;
  localparam int NIBBLE_W          = 4;
  localparam int DEF_INPUT_WIDTH   = 32;
  localparam int DEF_DIGITS        = 10;

  // Control handed from the sequencer to every digit cell.
  typedef struct packed {
    logic clear;
    logic step;
  } cell_ctrl_t;

endpackage

// ===== src/b2b_cell.sv =====
// ----------------------------------------------------------------------------
// b2b_cell
// One decimal digit of the shift-and-add-3 chain.
// ----------------------------------------------------------------------------
module b2b_cell (
  input  logic                       clk,
  input  b2b_pkg::cell_ctrl_t        ctrl,
  input  logic                       carry_in,
  output logic                       carry_out,
  output logic [b2b_pkg::NIBBLE_W-1:0] digit
);

  logic [b2b_pkg::NIBBLE_W-1:0] digit_r;
  logic [b2b_pkg::NIBBLE_W-1:0] digit_nxt;
  logic [b2b_pkg::NIBBLE_W-1:0] adj;

  // A digit of five or more would reach ten after doubling, so add three first.
  always_comb begin
    if (digit_r >= b2b_pkg::NIBBLE_W'(5)) begin
      adj = digit_r + b2b_pkg::NIBBLE_W'(3);
    end else begin
      adj = digit_r;
    end
  end

  assign carry_out = adj[b2b_pkg::NIBBLE_W-1];

  always_comb begin
    if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.step) begin
      digit_nxt = {adj[b2b_pkg::NIBBLE_W-2:0], carry_in};
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

// ===== src/binary_to_bcd.sv =====
// ----------------------------------------------------------------------------
// binary_to_bcd
// Converts an unsigned binary value to packed BCD with a digit count.
// ----------------------------------------------------------------------------
// Usage: one transaction on the in_ channel (in_valid, in_stall, in_value)
// gives one transaction on the out_ channel (out_valid, out_stall,
// out_bcd_digits, out_digit_count). Only the low INPUT_WIDTH bits of the
// value take part. Decimal digit k sits in bits 4k+3 down to 4k, and the
// count is the number of significant digits, never below one.
// A row of DIGITS cells holds the decimal digits; the binary value is shifted
// into it one bit per cycle; after INPUT_WIDTH shifts the sequencer moves from
// ST_RUN to ST_FLUSH, which loads the result into the output register, and
// a new transaction is accepted only once the last result has left the cells.
// in_stall is high while a conversion is in flight. The output register is
// separate from the cell row, so a new value is accepted while a result waits
// to be taken; a finished conversion waits in the cells until the output
// register is free. A stalled result holds its value.
// Reset clears the sequencer and the output valid; the data registers are not reset.
// ----------------------------------------------------------------------------
module binary_to_bcd #(
  parameter int INPUT_WIDTH = b2b_pkg::DEF_INPUT_WIDTH,
  parameter int DIGITS      = b2b_pkg::DEF_DIGITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [b2b_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [b2b_pkg::BCD_W-1:0]   out_bcd_digits,
  output logic [b2b_pkg::COUNT_W-1:0] out_digit_count
);

  localparam int STEP_W = $clog2(INPUT_WIDTH);
  localparam int CNT_W  = $clog2(DIGITS + 1);
  localparam int FULL_W = DIGITS * b2b_pkg::NIBBLE_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [INPUT_WIDTH-1:0]      shift_r, shift_nxt;
  logic [INPUT_WIDTH-1:0]      load_val;
  logic                        out_valid_r, out_valid_nxt;
  logic [b2b_pkg::BCD_W-1:0]   bcd_r;
  logic [b2b_pkg::COUNT_W-1:0] count_r;
  logic                        in_take;
  logic                        out_free;
  logic                        xfer;
  b2b_pkg::cell_ctrl_t         ctrl;

  logic [DIGITS:0]             carry;
  logic [b2b_pkg::NIBBLE_W-1:0] digit [DIGITS];
  logic [FULL_W-1:0]           bcd_full;
  logic [b2b_pkg::BCD_W-1:0]   bcd_fit;
  logic [CNT_W-1:0]            cnt;
  logic [b2b_pkg::COUNT_W-1:0] cnt_fit;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign xfer     = (state_r == ST_FLUSH) && out_free;

  generate
    if (INPUT_WIDTH > b2b_pkg::VALUE_W) begin : g_ext
      assign load_val = {{(INPUT_WIDTH - b2b_pkg::VALUE_W){1'b0}}, in_value};
    end else begin : g_cut
      assign load_val = in_value[INPUT_WIDTH-1:0];
    end
  endgenerate

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    shift_nxt  = shift_r;
    ctrl.clear = 1'b0;
    ctrl.step  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          shift_nxt  = load_val;
          step_nxt   = STEP_W'(INPUT_WIDTH - 1);
          ctrl.clear = 1'b1;
          state_nxt  = ST_RUN;
        end
      end
      ST_RUN: begin
        ctrl.step = 1'b1;
        shift_nxt = {shift_r[INPUT_WIDTH-2:0], 1'b0};
        step_nxt  = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign carry[0] = shift_r[INPUT_WIDTH-1];

  generate
    for (genvar k = 0; k < DIGITS; k++) begin : g_cell
      b2b_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (carry[k]),
        .carry_out (carry[k+1]),
        .digit     (digit[k])
      );
      assign bcd_full[k*b2b_pkg::NIBBLE_W +: b2b_pkg::NIBBLE_W] = digit[k];
    end
  endgenerate

  always_comb begin
    cnt = '0;
    for (int k = 0; k < DIGITS; k++) begin
      if (digit[k] != '0) begin
        cnt = CNT_W'(k + 1);
      end
    end
    if (cnt == '0) begin
      cnt = CNT_W'(1);
    end
  end

  generate
    if (FULL_W >= b2b_pkg::BCD_W) begin : g_bcd_cut
      assign bcd_fit = bcd_full[b2b_pkg::BCD_W-1:0];
    end else begin : g_bcd_ext
      assign bcd_fit = {{(b2b_pkg::BCD_W - FULL_W){1'b0}}, bcd_full};
    end
    if (CNT_W >= b2b_pkg::COUNT_W) begin : g_cnt_cut
      assign cnt_fit = cnt[b2b_pkg::COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign cnt_fit = {{(b2b_pkg::COUNT_W - CNT_W){1'b0}}, cnt};
    end
  endgenerate

  always_comb begin
    if (xfer) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    shift_r <= shift_nxt;
    if (xfer) begin
      bcd_r   <= bcd_fit;
      count_r <= cnt_fit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bcd_digits  = bcd_r;
  assign out_digit_count = count_r;

`ifndef SYNTHESIS
  logic digit_bad;

  always_comb begin
    digit_bad = 1'b0;
    for (int k = 0; k < DIGITS; k++) begin
      if (digit[k] > b2b_pkg::NIBBLE_W'(9)) begin
        digit_bad = 1'b1;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_RUN)
    else $error("accepted transaction did not start a conversion");

  a_result_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FLUSH)
    else $error("result appeared without a finished conversion");

  a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH |-> !digit_bad)
    else $error("cell holds a digit above nine");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(bcd_r) && $stable(count_r))
    else $error("stalled result was overwritten");
`endif

endmodule
